@@ rtl/pseudo_3d_road_pixel_generator_macros.svh @@
// Assertion macros shared by the road generator modules.
`ifndef PSEUDO_3D_ROAD_PIXEL_GENERATOR_MACROS_SVH
`define PSEUDO_3D_ROAD_PIXEL_GENERATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define R3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define R3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/r3d_pkg.sv @@
package r3d_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int X_W           = 7;
  localparam int Y_W           = 6;

  localparam int DIVD_W  = 16;
  localparam int DIVS_W  = 8;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int STEP_W  = 14;
  localparam int TEXV_W  = 9;
  localparam int U_W     = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] SKY_Y0      = 8'd32;
  localparam logic [9:0] SKY_STEP    = 10'd70;
  localparam logic [7:0] BAND_IN_LO  = 8'd195;
  localparam logic [7:0] BAND_IN_HI  = 8'd225;
  localparam logic [7:0] CENTER_HALF = 8'd15;
  localparam logic [7:0] ROAD_EDGE   = 8'd250;

  localparam logic [7:0] COL_SKY_B   = 8'd255;
  localparam logic [7:0] COL_BAND    = 8'd200;
  localparam logic [7:0] ROAD_A_R    = 8'd4;
  localparam logic [7:0] ROAD_A_G    = 8'd7;
  localparam logic [7:0] ROAD_A_B    = 8'd5;
  localparam logic [7:0] ROAD_B_R    = 8'd7;
  localparam logic [7:0] ROAD_B_G    = 8'd7;
  localparam logic [7:0] ROAD_B_B    = 8'd6;
  localparam logic [7:0] GRASS_A_R   = 8'd21;
  localparam logic [7:0] GRASS_A_G   = 8'd80;
  localparam logic [7:0] GRASS_A_B   = 8'd0;
  localparam logic [7:0] GRASS_B_R   = 8'd26;
  localparam logic [7:0] GRASS_B_G   = 8'd60;
  localparam logic [7:0] GRASS_B_B   = 8'd0;

  typedef enum logic [1:0] {
    REG_DEPTH_NUM   = 2'd0,
    REG_SCROLL_STEP = 2'd1,
    REG_TURN_LIMIT  = 2'd2,
    REG_TURN_DELAY  = 2'd3
  } r3d_reg_e;

  typedef struct packed {
    logic [15:0] depth_num;
    logic [8:0]  scroll_step;
    logic [6:0]  turn_limit;
    logic [7:0]  turn_delay;
  } r3d_cfg_t;

  typedef struct packed {
    logic           line_start;
    logic           last;
    logic [Y_W-1:0] y;
  } r3d_item_t;

endpackage

@@ rtl/r3d_front.sv @@
`include "pseudo_3d_road_pixel_generator_macros.svh"

module r3d_front import r3d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [X_W-1:0] pixel_x_i,
  input  logic [Y_W-1:0] pixel_y_i,
  output logic           head_valid_o,
  output r3d_item_t      head_o,
  input  logic           pop_i
);

  r3d_item_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 push;
  r3d_item_t            item;

  assign in_stall_o   = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    item.line_start = (pixel_x_i == '0);
    item.last       = (pixel_x_i == X_W'(SCREEN_WIDTH - 1)) &&
                      (pixel_y_i == Y_W'(SCREEN_HEIGHT - 1));
    item.y          = pixel_y_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  `R3D_ASSERT(a_pop_nonempty, !pop_i || (cnt_q != '0), "queue popped while empty")
  `R3D_ASSERT_NEXT(a_push_count, push && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a transfer")

endmodule

@@ rtl/r3d_div.sv @@
module r3d_div import r3d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVS_W-1:0]    rem_q, dsr_q;
  logic [DIVD_W-1:0]    quo_q;
  logic [DIVS_W:0]      trial, diff;
  logic                 fits;

  assign trial  = {rem_q, quo_q[DIVD_W-1]};
  assign diff   = trial - {1'b0, dsr_q};
  assign fits   = (trial >= {1'b0, dsr_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], fits};
    end
  end

endmodule

@@ rtl/r3d_back.sv @@
`include "pseudo_3d_road_pixel_generator_macros.svh"

module r3d_back import r3d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  r3d_cfg_t          cfg_i,
  input  logic              head_valid_i,
  input  r3d_item_t         head_i,
  output logic              pop_o,
  output logic              div_start_o,
  output logic [DIVD_W-1:0] div_dividend_o,
  output logic [DIVS_W-1:0] div_divisor_o,
  input  logic              div_done_i,
  input  logic [DIVD_W-1:0] div_quot_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              frame_done_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_ULD  = 6'b010000,
    ST_PIX  = 6'b100000
  } r3d_state_e;

  r3d_state_e st_q, st_d;

  logic signed [7:0]   turn_q;
  logic                turn_pos_q;
  logic [7:0]          frame_cnt_q;
  logic [TEXV_W-1:0]   scroll_q;
  logic [STEP_W-1:0]   step_q;
  logic [TEXV_W-1:0]   texv_q;
  logic [U_W-1:0]      u_q;
  logic                sky_q;
  logic signed [22:0]  prod1_q;
  logic signed [27:0]  prod2_q;

  logic                out_valid_q;
  logic [7:0]          red_q, green_q, blue_q;
  logic                frame_done_q;

  logic                out_free, emit;
  logic signed [12:0]  curve_off;
  logic [U_W-1:0]      u_mag;
  logic [U_W-7:0]      u_dist;
  logic                band, stripe;
  logic [7:0]          y_ext, sky_lvl;
  logic [7:0]          red_d, green_d, blue_d;

  logic [7:0]          fc_inc;
  logic                follow;
  logic signed [8:0]   turn_ext, turn_nxt, lim, neg_lim;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = head_valid_i && out_free &&
                       (((st_q == ST_IDLE) && !head_i.line_start) || (st_q == ST_PIX));
  assign pop_o       = emit;
  assign div_start_o = (st_q == ST_IDLE) && head_valid_i && head_i.line_start;
  assign div_dividend_o = cfg_i.depth_num;
  assign div_divisor_o  = {1'b0, head_i.y, 1'b0} + DIVS_W'(8);

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign frame_done_o = frame_done_q;

  assign curve_off = $signed(prod1_q[22:10]) - $signed(13'(SCREEN_WIDTH / 2));

  always_comb begin
    u_mag   = u_q[U_W-1] ? (U_W'(0) - u_q) : u_q;
    u_dist  = u_mag[U_W-1:6];
    stripe  = texv_q[7];
    band    = (((u_dist > {18'd0, BAND_IN_LO}) && (u_dist < {18'd0, BAND_IN_HI})) ||
               (u_dist < {18'd0, CENTER_HALF})) && texv_q[8];
    y_ext   = {2'b00, head_i.y};
    sky_lvl = (y_ext > SKY_Y0) ? (y_ext - SKY_Y0) : 8'd0;
    if (sky_q) begin
      red_d   = sky_lvl;
      green_d = sky_lvl;
      blue_d  = COL_SKY_B;
    end else if (band) begin
      red_d   = COL_BAND;
      green_d = COL_BAND;
      blue_d  = COL_BAND;
    end else if (u_dist < {18'd0, ROAD_EDGE}) begin
      red_d   = stripe ? ROAD_A_R : ROAD_B_R;
      green_d = stripe ? ROAD_A_G : ROAD_B_G;
      blue_d  = stripe ? ROAD_A_B : ROAD_B_B;
    end else begin
      red_d   = stripe ? GRASS_A_R : GRASS_B_R;
      green_d = stripe ? GRASS_A_G : GRASS_B_G;
      blue_d  = stripe ? GRASS_A_B : GRASS_B_B;
    end
  end

  always_comb begin
    fc_inc   = (frame_cnt_q != 8'hFF) ? frame_cnt_q + 8'd1 : frame_cnt_q;
    follow   = (fc_inc > cfg_i.turn_delay);
    turn_ext = {turn_q[7], turn_q};
    turn_nxt = (follow == turn_pos_q) ? turn_ext + 9'sd1 : turn_ext - 9'sd1;
    lim      = $signed({2'b00, cfg_i.turn_limit});
    neg_lim  = 9'sd0 - lim;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (div_start_o) begin
          st_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done_i) begin
          st_d = ST_MUL1;
        end
      end
      ST_MUL1: st_d = ST_MUL2;
      ST_MUL2: st_d = ST_ULD;
      ST_ULD:  st_d = ST_PIX;
      ST_PIX: begin
        if (emit) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      turn_q      <= '0;
      turn_pos_q  <= 1'b1;
      frame_cnt_q <= '0;
      scroll_q    <= '0;
      step_q      <= '0;
      texv_q      <= '0;
      u_q         <= '0;
      sky_q       <= 1'b0;
    end else begin
      st_q <= st_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((st_q == ST_DIV) && div_done_i) begin
        step_q <= div_quot_i[STEP_W-1:0];
        sky_q  <= (div_quot_i[STEP_W-1:4] > SKY_STEP);
        texv_q <= scroll_q + div_quot_i[TEXV_W-1:0];
      end
      if (st_q == ST_ULD) begin
        u_q <= {{(U_W-28){prod2_q[27]}}, prod2_q} -
               {{(U_W-16){turn_q[7]}}, turn_q, 8'd0};
      end else if (emit) begin
        u_q <= u_q + {{(U_W-STEP_W){1'b0}}, step_q};
      end
      if (emit && head_i.last) begin
        scroll_q    <= scroll_q + cfg_i.scroll_step;
        frame_cnt_q <= fc_inc;
        if (turn_nxt > lim) begin
          turn_q     <= lim[7:0];
          turn_pos_q <= 1'b0;
        end else if (turn_nxt < neg_lim) begin
          turn_q     <= neg_lim[7:0];
          turn_pos_q <= 1'b1;
        end else begin
          turn_q <= turn_nxt[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_MUL1) begin
      prod1_q <= $signed({1'b0, step_q}) * turn_q;
    end
    if (st_q == ST_MUL2) begin
      prod2_q <= curve_off * $signed({1'b0, step_q});
    end
    if (emit) begin
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      frame_done_q <= head_i.last;
    end
  end

  `R3D_ASSERT(a_pop_state,
              !pop_o || (st_q == ST_IDLE) || (st_q == ST_PIX),
              "pixel left queue during line setup")
  `R3D_ASSERT_NEXT(a_div_seq,
                   (st_q == ST_DIV) && div_done_i,
                   st_q == ST_MUL1,
                   "line setup skipped after quotient")
  `R3D_ASSERT_NEXT(a_turn_lim,
                   emit && head_i.last,
                   (turn_ext <= lim) && (turn_ext >= neg_lim),
                   "turn outside its limit after frame end")

endmodule

@@ rtl/pseudo_3d_road_pixel_generator.sv @@
// Pseudo-3D road pixel generator.
// Pixel coordinates enter on the input channel (in_valid_i, in_stall_o,
// pixel_x_i, pixel_y_i) in raster order, and one colour per pixel leaves on
// the output channel (out_valid_o, out_stall_i, red_o, green_o, blue_o,
// frame_done_o). A transfer happens at a clock edge where valid is high and
// stall is low. The APB port sets the depth numerator, scroll step, turn
// limit and turn delay; the user must write it only while no pixel is in
// flight, as the block itself does not enforce this. A pixel inside a line
// passes through the queue and the output register, and the block takes one
// pixel per cycle while the receiver keeps up and no line is being set up.
// A pixel with column zero starts a line: a bit-serial divider computes the
// perspective step and two registered multiplies form the start coordinate.
// A two-entry queue between the input and the line engine keeps accepting
// pixels while the engine or the receiver stalls; when the output register
// is held by out_stall_i the queue fills and then in_stall_o rises.
// Reset clears the queue, the output valid flag and the road state, and loads
// the configuration registers with their default values.
module pseudo_3d_road_pixel_generator import r3d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [X_W-1:0] pixel_x_i,
  input  logic [Y_W-1:0] pixel_y_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o,
  output logic           frame_done_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  r3d_cfg_t          cfg_q;
  r3d_reg_e          reg_idx;
  logic              cfg_wr;
  logic              head_valid, pop;
  r3d_item_t         head;
  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quot;
  logic [DIVS_W-1:0] div_divisor;

  assign pready  = 1'b1;
  assign reg_idx = r3d_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_num   <= 16'd16384;
      cfg_q.scroll_step <= 9'd32;
      cfg_q.turn_limit  <= 7'd64;
      cfg_q.turn_delay  <= 8'd20;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEPTH_NUM:   cfg_q.depth_num   <= pwdata[15:0];
        REG_SCROLL_STEP: cfg_q.scroll_step <= pwdata[8:0];
        REG_TURN_LIMIT:  cfg_q.turn_limit  <= pwdata[6:0];
        REG_TURN_DELAY:  cfg_q.turn_delay  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEPTH_NUM:   prdata = {16'd0, cfg_q.depth_num};
      REG_SCROLL_STEP: prdata = {23'd0, cfg_q.scroll_step};
      REG_TURN_LIMIT:  prdata = {25'd0, cfg_q.turn_limit};
      REG_TURN_DELAY:  prdata = {24'd0, cfg_q.turn_delay};
      default:         prdata = '0;
    endcase
  end

  r3d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  r3d_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  r3d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

@@ verif/r3d_road_checker.sv @@
`timescale 1ns / 1ps

module r3d_road_checker import r3d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  logic [X_W-1:0] pixel_x_i,
  input  logic [Y_W-1:0] pixel_y_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  logic [7:0]     red_i,
  input  logic [7:0]     green_i,
  input  logic [7:0]     blue_i,
  input  logic           frame_done_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  output int             fail_count_o,
  output int             pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
  } color_t;

  color_t    exp_colors[$];
  color_t    want;
  color_t    pred;
  int        fails;
  r3d_cfg_t  cfg;

  int          turn;
  logic        turn_up;
  logic [7:0]  frames;
  logic [8:0]  scroll;
  logic [13:0] step;
  logic [8:0]  texv;
  logic [31:0] lat_u;
  logic        sky;

  task automatic begin_line(input logic [Y_W-1:0] y);
    int quot;
    int s;
    int curve;
    quot  = int'(cfg.depth_num) / (2 * int'(y) + 8);
    s     = quot & 'h3FFF;
    curve = (s * turn) >>> 10;
    step  = s[13:0];
    sky   = (s >> 4) > 70;
    texv  = scroll + s[8:0];
    lat_u = (curve - SCREEN_WIDTH / 2) * s - turn * 256;
  endtask

  task automatic finish_frame();
    int dir;
    dir    = turn_up ? 1 : -1;
    scroll = scroll + cfg.scroll_step;
    if (frames != 8'hFF) frames = frames + 8'd1;
    turn = turn + ((frames > cfg.turn_delay) ? dir : -dir);
    if (turn > int'(cfg.turn_limit)) begin
      turn    = int'(cfg.turn_limit);
      turn_up = 1'b0;
    end else if (turn < -int'(cfg.turn_limit)) begin
      turn    = -int'(cfg.turn_limit);
      turn_up = 1'b1;
    end
  endtask

  task automatic render_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                              output color_t c);
    logic [31:0] mag;
    logic [31:0] d;
    logic        band;
    if (x == 0) begin_line(y);
    c.frame_done = (x == SCREEN_WIDTH - 1) && (y == SCREEN_HEIGHT - 1);
    if (sky) begin
      if (y > 6'd32) c.red = 8'(y) - 8'd32;
      else c.red = 8'd0;
      c.green = c.red;
      c.blue  = 8'd255;
    end else begin
      mag  = lat_u[31] ? (32'd0 - lat_u) : lat_u;
      d    = mag >> 6;
      band = ((d > 195 && d < 225) || d < 15) && texv[8];
      if (band) begin
        c.red = 8'd200; c.green = 8'd200; c.blue = 8'd200;
      end else if (d < 250) begin
        if (texv[7]) begin
          c.red = 8'd4; c.green = 8'd7; c.blue = 8'd5;
        end else begin
          c.red = 8'd7; c.green = 8'd7; c.blue = 8'd6;
        end
      end else begin
        if (texv[7]) begin
          c.red = 8'd21; c.green = 8'd80; c.blue = 8'd0;
        end else begin
          c.red = 8'd26; c.green = 8'd60; c.blue = 8'd0;
        end
      end
    end
    lat_u = lat_u + 32'(step);
    if (c.frame_done) finish_frame();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      exp_colors.delete();
      fails           = 0;
      cfg.depth_num   = 16'd16384;
      cfg.scroll_step = 9'd32;
      cfg.turn_limit  = 7'd64;
      cfg.turn_delay  = 8'd20;
      turn    = 0;
      turn_up = 1'b1;
      frames  = '0;
      scroll  = '0;
      step    = '0;
      texv    = '0;
      lat_u   = '0;
      sky     = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (r3d_reg_e'(paddr[3:2]))
          REG_DEPTH_NUM:   cfg.depth_num   = pwdata[15:0];
          REG_SCROLL_STEP: cfg.scroll_step = pwdata[8:0];
          REG_TURN_LIMIT:  cfg.turn_limit  = pwdata[6:0];
          REG_TURN_DELAY:  cfg.turn_delay  = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (exp_colors.size() == 0) begin
          $error("Unexpected color transfer: red %0d green %0d blue %0d frame_done %0d",
                 red_i, green_i, blue_i, frame_done_i);
          fails++;
        end else begin
          want = exp_colors.pop_front();
          if (red_i !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red_i);
            fails++;
          end
          if (green_i !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green_i);
            fails++;
          end
          if (blue_i !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue_i);
            fails++;
          end
          if (frame_done_i !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, frame_done_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        render_pixel(pixel_x_i, pixel_y_i, pred);
        exp_colors.push_back(pred);
      end
    end
    fail_count_o <= fails;
    pending_o    <= exp_colors.size();
  end

endmodule

@@ verif/tb_pseudo_3d_road_pixel_generator.sv @@
`timescale 1ns / 1ps

module tb_pseudo_3d_road_pixel_generator;
  import r3d_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_stall;
  logic [X_W-1:0] pixel_x;
  logic [Y_W-1:0] pixel_y;
  logic           out_valid;
  logic           out_stall;
  logic [7:0]     red;
  logic [7:0]     green;
  logic [7:0]     blue;
  logic           frame_done;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [3:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  int fail_count;
  int pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int cycles;
  bit hold_req;

  pseudo_3d_road_pixel_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .frame_done_o (frame_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  r3d_road_checker u_road_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .frame_done_i (frame_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // The receiver stalls at random, or for one long stretch when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input r3d_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_road(input logic [15:0] num, input logic [8:0] scroll_step,
                          input logic [6:0] limit, input logic [7:0] delay);
    write_reg(REG_DEPTH_NUM, 32'(num));
    write_reg(REG_SCROLL_STEP, 32'(scroll_step));
    write_reg(REG_TURN_LIMIT, 32'(limit));
    write_reg(REG_TURN_DELAY, 32'(delay));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly lines that open with column zero, followed by a few pixels and
  // often by the last pixel of the frame; the rest are stray pixels.
  task automatic run_road(input int n_items);
    int             done;
    int             k;
    logic [Y_W-1:0] y;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_pixel(X_W'($urandom_range(127)), Y_W'($urandom_range(63)));
        done++;
      end else begin
        y = Y_W'($urandom_range(63));
        send_pixel('0, y);
        done++;
        k = $urandom_range(1, 6);
        repeat (k) begin
          if ($urandom_range(4) == 0) begin
            send_pixel(X_W'($urandom_range(1, 127)), Y_W'($urandom_range(63)));
          end else begin
            send_pixel(X_W'($urandom_range(1, 127)), y);
          end
          done++;
        end
        if ($urandom_range(2) == 0) begin
          send_pixel(X_W'(SCREEN_WIDTH - 1), Y_W'(SCREEN_HEIGHT - 1));
          done++;
        end
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    pixel_x      = '0;
    pixel_y      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_req     = 1'b0;
    snd_idle_pct = 6;
    rcv_idle_pct = 64;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default settings: pixels before any line start, sky lines, road lines with
    // rows past the horizon, and whole-frame ends.
    send_pixel(7'd5, 6'd3);
    send_pixel(7'd127, 6'd63);
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd127, 6'd0);
    send_pixel(7'd64, 6'd40);
    send_pixel(7'd1, 6'd63);
    send_pixel(7'd0, 6'd63);
    send_pixel(7'd1, 6'd63);
    send_pixel(7'd63, 6'd63);
    send_pixel(7'd64, 6'd63);
    send_pixel(7'd126, 6'd63);
    send_pixel(7'd127, 6'd63);
    send_pixel(7'd0, 6'd4);
    send_pixel(7'd100, 6'd4);
    send_pixel(7'd0, 6'd3);
    send_pixel(7'd0, 6'd31);
    send_pixel(7'd50, 6'd31);
    send_pixel(7'd0, 6'd33);
    send_pixel(7'd127, 6'd33);
    send_pixel(7'd127, 6'd63);
    run_road(300);

    drain();
    set_road(16'd65535, 9'd511, 7'd127, 8'd255);
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd0, 6'd63);
    send_pixel(7'd127, 6'd63);
    run_road(300);

    snd_idle_pct = 64;
    rcv_idle_pct = 6;
    drain();
    set_road(16'd0, 9'd0, 7'd0, 8'd0);
    send_pixel(7'd0, 6'd10);
    send_pixel(7'd64, 6'd10);
    send_pixel(7'd127, 6'd63);
    run_road(250);

    drain();
    set_road(16'd1, 9'd1, 7'd1, 8'd0);
    run_road(100);
    drain();
    set_road(16'($urandom_range(1, 65535)), 9'($urandom_range(511)),
             7'($urandom_range(127)), 8'($urandom_range(255)));
    run_road(150);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    drain();
    set_road(16'($urandom_range(1, 65535)), 9'($urandom_range(511)),
             7'($urandom_range(127)), 8'($urandom_range(255)));
    run_road(200);
    hold_req = 1'b1;
    run_road(100);
    drain();
    run_road(100);

    drain();
    set_road(16'd900, 9'd32, 7'd127, 8'd255);
    run_road(200);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
